@@ hw/rtl/mpsm_pkg.sv @@
// ----------------------------------------------------------------------------
// mpsm_pkg: shared definitions of the multi-pattern string matcher
// Sizes, item codes, status codes and the records passed between the parts.
// ----------------------------------------------------------------------------
package mpsm_pkg;

    // Trie and alphabet sizes.
    localparam int NODE_W       = 8;
    localparam int SYM_W        = 8;
    localparam int MAX_NODES    = 256;
    localparam int ALPHABET     = 256;
    localparam int MAX_PATTERNS = 64;
    localparam int GT_AW        = NODE_W + SYM_W;
    localparam int GT_DEPTH     = MAX_NODES * ALPHABET;
    localparam int CNT_W        = 7;
    localparam int PAT_W        = 7;
    localparam int TOT_W        = 32;

    // Item kinds.
    localparam logic [1:0] KIND_PAT   = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_BUILD = 2'd2;
    localparam logic [1:0] KIND_TEXT  = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_ORDER = 2'd2;

    // A classified input item.
    typedef struct packed {
        logic             is_pat;
        logic             is_end;
        logic             is_build;
        logic             is_text;
        logic [SYM_W-1:0] symbol;
        logic             last;
    } t_cmd;

    // One result item.
    typedef struct packed {
        logic [CNT_W-1:0] here;
        logic [TOT_W-1:0] total;
        logic [1:0]       status;
        logic             done;
    } t_res;

    // Engine status seen by the front.
    typedef struct packed {
        logic clearing;
    } t_eng_stat;

endpackage

@@ hw/rtl/mpsm_front.sv @@
// ----------------------------------------------------------------------------
// mpsm_front: input queue and classifier
// Accepts input beats, decodes the kind and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module mpsm_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  i_kind,
    input  logic [mpsm_pkg::SYM_W-1:0]  i_symbol,
    input  logic                        i_text_last,
    input  mpsm_pkg::t_eng_stat         i_stat,
    output logic                        o_cmd_valid,
    output mpsm_pkg::t_cmd              o_cmd,
    input  logic                        i_cmd_pop
);

    mpsm_pkg::t_cmd r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    mpsm_pkg::t_cmd dec;
    logic           acc;
    logic           rel;

    // Classify the incoming beat.
    always_comb begin
        dec        = '0;
        dec.symbol = i_symbol;
        dec.last   = i_text_last;
        unique case (i_kind)
            mpsm_pkg::KIND_PAT:   dec.is_pat   = 1'b1;
            mpsm_pkg::KIND_END:   dec.is_end   = 1'b1;
            mpsm_pkg::KIND_BUILD: dec.is_build = 1'b1;
            mpsm_pkg::KIND_TEXT:  dec.is_text  = 1'b1;
            default:              dec.is_text  = 1'b1;
        endcase
    end

    // Queue handshake; no beat is taken while the memories are cleared.
    assign full        = (r_cnt == 2'd2) || i_stat.clearing;
    assign acc         = push && !full;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign rel         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_q[r_wp] <= dec;
        end
    end

    // Queue pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (acc) begin
                r_wp <= ~r_wp;
            end
            if (rel) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, acc} - {1'b0, rel};
        end
    end

endmodule

@@ hw/rtl/mpsm_engine.sv @@
// ----------------------------------------------------------------------------
// mpsm_engine: trie builder and text scanner
// Sequencer that owns the goto, failure, count and walk-queue memories.
// ----------------------------------------------------------------------------
module mpsm_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  mpsm_pkg::t_cmd      i_cmd,
    output logic                o_cmd_pop,
    input  logic                i_res_full,
    output logic                o_res_push,
    output mpsm_pkg::t_res      o_res,
    output mpsm_pkg::t_eng_stat o_stat
);

    localparam int NW = mpsm_pkg::NODE_W;
    localparam int SW = mpsm_pkg::SYM_W;
    localparam int AW = mpsm_pkg::GT_AW;
    localparam int CW = mpsm_pkg::CNT_W;
    localparam int TW = mpsm_pkg::TOT_W;
    localparam int QW = NW + 1;

    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_P_EV  = 5'd2;
    localparam logic [4:0] S_E_EV  = 5'd3;
    localparam logic [4:0] S_RB_RD = 5'd4;
    localparam logic [4:0] S_RB_EV = 5'd5;
    localparam logic [4:0] S_POP   = 5'd6;
    localparam logic [4:0] S_POPW  = 5'd7;
    localparam logic [4:0] S_CH_RD = 5'd8;
    localparam logic [4:0] S_CH_EV = 5'd9;
    localparam logic [4:0] S_F_RD  = 5'd10;
    localparam logic [4:0] S_F_EV  = 5'd11;
    localparam logic [4:0] S_F_FL  = 5'd12;
    localparam logic [4:0] S_C1    = 5'd13;
    localparam logic [4:0] S_C2    = 5'd14;
    localparam logic [4:0] S_T_RD  = 5'd15;
    localparam logic [4:0] S_T_EV  = 5'd16;
    localparam logic [4:0] S_T_CNT = 5'd17;
    localparam logic [4:0] S_RESP  = 5'd18;

    // Memories.
    logic [NW:0]   gt_mem [mpsm_pkg::GT_DEPTH];
    logic [NW-1:0] fl_mem [mpsm_pkg::MAX_NODES];
    logic [CW-1:0] cn_mem [mpsm_pkg::MAX_NODES];
    logic [NW-1:0] bq_mem [mpsm_pkg::MAX_NODES];

    logic [NW:0]   gt_rd, gt_wd;
    logic [AW-1:0] gt_ra, gt_wa;
    logic          gt_we;
    logic [NW-1:0] fl_rd, fl_wd, fl_ra, fl_wa;
    logic          fl_we;
    logic [CW-1:0] cn_rd, cn_wd;
    logic [NW-1:0] cn_ra, cn_wa;
    logic          cn_we;
    logic [NW-1:0] bq_rd, bq_wd, bq_ra, bq_wa;
    logic          bq_we;

    // Control and trie state.
    logic [4:0]    r_state;
    logic [AW-1:0] r_clr;
    logic [NW-1:0] r_nodes, r_ins, r_scan, r_cur, r_nxt, r_f, r_st;
    logic [SW-1:0] r_sym, r_s;
    logic [TW-1:0] r_total;
    logic          r_built, r_broken, r_last;
    logic [mpsm_pkg::PAT_W-1:0] r_pats;
    logic [QW-1:0] r_head, r_tail;
    logic [CW-1:0] r_cf;
    mpsm_pkg::t_res r_res;

    logic          g_valid;
    logic [NW-1:0] g_node;
    logic          take;
    logic          q_room;
    logic          node_room;
    logic [TW:0]   sum;
    logic [TW-1:0] sat;

    assign g_valid   = gt_rd[NW];
    assign g_node    = gt_rd[NW-1:0];
    assign take      = (r_state == S_IDLE) && i_cmd_valid && !i_res_full;
    assign q_room    = (r_tail < QW'(mpsm_pkg::MAX_NODES));
    assign node_room = ({1'b0, r_nodes} + 1'b1) < QW'(mpsm_pkg::MAX_NODES);
    assign sum       = {1'b0, r_total} + {{(TW+1-CW){1'b0}}, cn_rd};
    assign sat       = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];

    assign o_cmd_pop       = take;
    assign o_res_push      = (r_state == S_RESP);
    assign o_res           = r_res;
    assign o_stat.clearing = (r_state == S_CLR);

    // Memory read addresses and write ports, chosen by state.
    always_comb begin
        gt_ra = {r_f, r_s};
        fl_ra = r_f;
        cn_ra = r_ins;
        bq_ra = r_head[NW-1:0];
        gt_we = 1'b0; gt_wa = {r_ins, r_sym}; gt_wd = '0;
        fl_we = 1'b0; fl_wa = r_nxt;          fl_wd = '0;
        cn_we = 1'b0; cn_wa = r_nxt;          cn_wd = '0;
        bq_we = 1'b0; bq_wa = r_tail[NW-1:0]; bq_wd = g_node;
        unique case (r_state)
            S_CLR: begin
                gt_we = 1'b1;
                gt_wa = r_clr;
                fl_wa = r_clr[NW-1:0];
                cn_wa = r_clr[NW-1:0];
                fl_we = (r_clr[AW-1:NW] == '0);
                cn_we = (r_clr[AW-1:NW] == '0);
            end
            S_IDLE: begin
                gt_ra = {r_ins, i_cmd.symbol};
            end
            S_P_EV: begin
                if (!g_valid && node_room) begin
                    gt_we = 1'b1;
                    gt_wd = {1'b1, r_nodes + 1'b1};
                end
            end
            S_E_EV: begin
                cn_we = 1'b1;
                cn_wa = r_ins;
                cn_wd = cn_rd + 1'b1;
            end
            S_RB_RD: begin
                gt_ra = {{NW{1'b0}}, r_s};
            end
            S_RB_EV: begin
                if (!g_valid) begin
                    gt_we = 1'b1;
                    gt_wa = {{NW{1'b0}}, r_s};
                    gt_wd = {1'b1, {NW{1'b0}}};
                end else if (g_node != '0 && q_room) begin
                    fl_we = 1'b1;
                    fl_wa = g_node;
                    bq_we = 1'b1;
                end
            end
            S_CH_RD: begin
                gt_ra = {r_cur, r_s};
                fl_ra = r_cur;
            end
            S_CH_EV: begin
                bq_we = g_valid && q_room;
            end
            S_F_EV: begin
                if (g_valid) begin
                    fl_we = 1'b1;
                    fl_wd = g_node;
                    cn_ra = g_node;
                end
            end
            S_C1: begin
                cn_ra = r_nxt;
            end
            S_C2: begin
                cn_we = 1'b1;
                cn_wd = cn_rd + r_cf;
            end
            S_T_RD: begin
                gt_ra = {r_st, r_sym};
                fl_ra = r_st;
            end
            S_T_EV: begin
                cn_ra = g_node;
            end
            default: begin
            end
        endcase
    end

    // Goto table.
    always_ff @(posedge i_clk) begin
        if (gt_we) begin
            gt_mem[gt_wa] <= gt_wd;
        end
        gt_rd <= gt_mem[gt_ra];
    end

    // Failure links.
    always_ff @(posedge i_clk) begin
        if (fl_we) begin
            fl_mem[fl_wa] <= fl_wd;
        end
        fl_rd <= fl_mem[fl_ra];
    end

    // Match counts.
    always_ff @(posedge i_clk) begin
        if (cn_we) begin
            cn_mem[cn_wa] <= cn_wd;
        end
        cn_rd <= cn_mem[cn_ra];
    end

    // Breadth-first walk queue.
    always_ff @(posedge i_clk) begin
        if (bq_we) begin
            bq_mem[bq_wa] <= bq_wd;
        end
        bq_rd <= bq_mem[bq_ra];
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_nodes  <= '0;
            r_ins    <= '0;
            r_scan   <= '0;
            r_total  <= '0;
            r_built  <= 1'b0;
            r_broken <= 1'b0;
            r_pats   <= '0;
            r_head   <= '0;
            r_tail   <= '0;
        end else begin
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == {AW{1'b1}}) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (take) begin
                        r_sym       <= i_cmd.symbol;
                        r_last      <= i_cmd.last;
                        r_res.here  <= '0;
                        r_res.total <= r_total;
                        r_res.done  <= 1'b0;
                        priority if (i_cmd.is_pat) begin
                            if (r_built) begin
                                r_res.status <= mpsm_pkg::ST_ORDER;
                                r_state      <= S_RESP;
                            end else if (r_broken) begin
                                r_res.status <= mpsm_pkg::ST_FULL;
                                r_state      <= S_RESP;
                            end else begin
                                r_res.status <= mpsm_pkg::ST_OK;
                                r_state      <= S_P_EV;
                            end
                        end else if (i_cmd.is_end) begin
                            if (r_built) begin
                                r_res.status <= mpsm_pkg::ST_ORDER;
                                r_state      <= S_RESP;
                            end else if (r_broken ||
                                r_pats >= mpsm_pkg::PAT_W'(mpsm_pkg::MAX_PATTERNS)) begin
                                r_res.status <= mpsm_pkg::ST_FULL;
                                r_broken     <= 1'b0;
                                r_ins        <= '0;
                                r_state      <= S_RESP;
                            end else if (r_ins == '0) begin
                                r_res.status <= mpsm_pkg::ST_ORDER;
                                r_state      <= S_RESP;
                            end else begin
                                r_res.status <= mpsm_pkg::ST_OK;
                                r_state      <= S_E_EV;
                            end
                        end else if (i_cmd.is_build) begin
                            if (r_built || r_ins != '0 || r_broken) begin
                                r_res.status <= mpsm_pkg::ST_ORDER;
                                r_state      <= S_RESP;
                            end else begin
                                r_res.status <= mpsm_pkg::ST_OK;
                                r_s          <= '0;
                                r_head       <= '0;
                                r_tail       <= '0;
                                r_state      <= S_RB_RD;
                            end
                        end else begin
                            if (!r_built) begin
                                r_res.status <= mpsm_pkg::ST_ORDER;
                                r_state      <= S_RESP;
                            end else begin
                                r_res.status <= mpsm_pkg::ST_OK;
                                r_st         <= r_scan;
                                r_state      <= S_T_RD;
                            end
                        end
                    end
                end
                S_P_EV: begin
                    if (g_valid) begin
                        r_ins <= g_node;
                    end else if (node_room) begin
                        r_nodes <= r_nodes + 1'b1;
                        r_ins   <= r_nodes + 1'b1;
                    end else begin
                        r_broken     <= 1'b1;
                        r_res.status <= mpsm_pkg::ST_FULL;
                    end
                    r_state <= S_RESP;
                end
                S_E_EV: begin
                    r_pats  <= r_pats + 1'b1;
                    r_ins   <= '0;
                    r_state <= S_RESP;
                end
                S_RB_RD: begin
                    r_state <= S_RB_EV;
                end
                S_RB_EV: begin
                    if (g_valid && g_node != '0 && q_room) begin
                        r_tail <= r_tail + 1'b1;
                    end
                    r_s     <= r_s + 1'b1;
                    r_state <= (r_s == {SW{1'b1}}) ? S_POP : S_RB_RD;
                end
                S_POP: begin
                    if (r_head < r_tail) begin
                        r_state <= S_POPW;
                    end else begin
                        r_built <= 1'b1;
                        r_scan  <= '0;
                        r_total <= '0;
                        r_res   <= '{here: '0, total: '0,
                                    status: mpsm_pkg::ST_OK, done: 1'b1};
                        r_state <= S_RESP;
                    end
                end
                S_POPW: begin
                    r_cur   <= bq_rd;
                    r_head  <= r_head + 1'b1;
                    r_s     <= '0;
                    r_state <= S_CH_RD;
                end
                S_CH_RD: begin
                    r_state <= S_CH_EV;
                end
                S_CH_EV: begin
                    if (g_valid) begin
                        r_nxt <= g_node;
                        r_f   <= fl_rd;
                        if (q_room) begin
                            r_tail <= r_tail + 1'b1;
                        end
                        r_state <= S_F_RD;
                    end else begin
                        r_s     <= r_s + 1'b1;
                        r_state <= (r_s == {SW{1'b1}}) ? S_POP : S_CH_RD;
                    end
                end
                S_F_RD: begin
                    r_state <= S_F_EV;
                end
                S_F_EV: begin
                    r_state <= g_valid ? S_C1 : S_F_FL;
                end
                S_F_FL: begin
                    r_f     <= fl_rd;
                    r_state <= S_F_RD;
                end
                S_C1: begin
                    r_cf    <= cn_rd;
                    r_state <= S_C2;
                end
                S_C2: begin
                    r_s     <= r_s + 1'b1;
                    r_state <= (r_s == {SW{1'b1}}) ? S_POP : S_CH_RD;
                end
                S_T_RD: begin
                    r_state <= S_T_EV;
                end
                S_T_EV: begin
                    if (g_valid) begin
                        r_st    <= g_node;
                        r_state <= S_T_CNT;
                    end else begin
                        r_st    <= fl_rd;
                        r_state <= S_T_RD;
                    end
                end
                S_T_CNT: begin
                    r_res.here  <= cn_rd;
                    r_res.total <= sat;
                    r_res.done  <= r_last;
                    if (r_last) begin
                        r_scan  <= '0;
                        r_total <= '0;
                    end else begin
                        r_scan  <= r_st;
                        r_total <= sat;
                    end
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // A result is pushed only into a queue with room.
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result pushed into a full queue");

    // The trie never shrinks.
    a_nodes_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(r_state) != S_CLR |-> r_nodes >= $past(r_nodes))
        else $error("node count decreased");

    // The walk queue never runs past the trie size.
    a_tail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail && r_tail <= QW'(mpsm_pkg::MAX_NODES))
        else $error("walk queue pointers out of range");

endmodule

@@ hw/rtl/mpsm_res_q.sv @@
// ----------------------------------------------------------------------------
// mpsm_res_q: result queue
// Two-entry queue that holds finished results until the consumer pops them.
// ----------------------------------------------------------------------------
module mpsm_res_q (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mpsm_pkg::t_res i_res,
    output logic           o_full,
    output logic           empty,
    input  logic           pop,
    output mpsm_pkg::t_res o_res
);

    mpsm_pkg::t_res r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           rel;

    assign o_full = (r_cnt == 2'd2);
    assign empty  = (r_cnt == 2'd0);
    assign rel    = pop && !empty;
    assign o_res  = r_q[r_rp];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_res;
        end
    end

    // Queue pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (rel) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, rel};
        end
    end

endmodule

@@ hw/rtl/multi_pattern_string_matcher.sv @@
// ----------------------------------------------------------------------------
// multi_pattern_string_matcher: Aho-Corasick multi-pattern matcher
// Builds a trie from pattern beats, sets failure links and scans text.
// ----------------------------------------------------------------------------
// After reset the block clears its goto, failure and count memories, one
// goto entry a cycle; full stays high during that pass. Each input beat
// then gives one result beat. A text byte reads the goto table and follows
// failure links one at a time until a goto hit, then reads the count, as
// the goto and failure memories each have one read port. A build item walks
// all 256 root letters, then fetches every trie node from the walk queue,
// tries each letter and follows failure links for each child. Short
// queues on both sides let input and output stall independently of the
// sequencer.
module multi_pattern_string_matcher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_symbol,
    input  logic        i_text_last,
    output logic        empty,
    input  logic        pop,
    output logic [6:0]  o_matches_here,
    output logic [31:0] o_total_matches,
    output logic [1:0]  o_status,
    output logic        o_done_res
);

    mpsm_pkg::t_eng_stat stat;
    mpsm_pkg::t_cmd      cmd;
    mpsm_pkg::t_res      eng_res;
    mpsm_pkg::t_res      out_res;
    logic                cmd_valid;
    logic                cmd_pop;
    logic                res_push;
    logic                res_full;

    // Front: input queue and classifier.
    mpsm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_kind      (i_kind),
        .i_symbol    (i_symbol),
        .i_text_last (i_text_last),
        .i_stat      (stat),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // Back: trie sequencer.
    mpsm_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (eng_res),
        .o_stat      (stat)
    );

    // Result queue.
    mpsm_res_q u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_res   (eng_res),
        .o_full  (res_full),
        .empty   (empty),
        .pop     (pop),
        .o_res   (out_res)
    );

    assign o_matches_here  = out_res.here;
    assign o_total_matches = out_res.total;
    assign o_status        = out_res.status;
    assign o_done_res      = out_res.done;

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the multi-pattern string matcher
// Loads patterns (including trie-full and pattern-table-full cases), builds
// the failure links, then scans text. Every result beat is compared with a
// behavioral Aho-Corasick model kept in this bench, or with a chk row's typed value.
// ----------------------------------------------------------------------------
module tb;

    localparam int WATCH_LIMIT = 600000;
    localparam int TEXT_ITEMS  = 870;

    // One expected result beat.
    typedef struct {
        logic [6:0]  here;
        logic [31:0] total;
        logic [1:0]  status;
        logic        done;
    } t_match_res;

    // One row of the directed stimulus; chk marks a typed expectation.
    typedef struct {
        logic [1:0] kind;
        logic [7:0] sym;
        logic       last;
        logic       chk;
        t_match_res res;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  i_kind = mpsm_pkg::KIND_PAT;
    logic [7:0]  i_symbol = 8'd0;
    logic        i_text_last = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [6:0]  o_matches_here;
    logic [31:0] o_total_matches;
    logic [1:0]  o_status;
    logic        o_done_res;

    // Matcher model state.
    logic       trie_valid [0:mpsm_pkg::GT_DEPTH-1];
    logic [7:0] trie_next  [0:mpsm_pkg::GT_DEPTH-1];
    logic [7:0] fail_node  [0:mpsm_pkg::MAX_NODES-1];
    int         node_count [0:mpsm_pkg::MAX_NODES-1];
    int         top_node, ins_at, scan_at, pat_count;
    logic [31:0] run_total;
    bit         is_built, pat_broken;

    t_match_res pending_res[$];
    int errors = 0, sent = 0, received = 0, idle_cycles = 0;
    int text_bytes = 0, match_sum = 0;
    int tx_idle = 10, rx_idle = 69;

    always #2 i_clk = ~i_clk;

    multi_pattern_string_matcher dut (.*);

    function automatic int slot(input int node, input int sym);
        return node * mpsm_pkg::ALPHABET + sym;
    endfunction

    // Sets failure links breadth-first and folds in the failure counts.
    function automatic void link_trie();
        int bq[$];
        int cur, nxt, f;
        for (int s = 0; s < mpsm_pkg::ALPHABET; s++) begin
            if (!trie_valid[slot(0, s)]) begin
                trie_valid[slot(0, s)] = 1'b1;
                trie_next[slot(0, s)] = 8'd0;
            end else if (trie_next[slot(0, s)] != 0) begin
                fail_node[trie_next[slot(0, s)]] = 8'd0;
                bq.push_back(trie_next[slot(0, s)]);
            end
        end
        while (bq.size() > 0) begin
            cur = bq.pop_front();
            for (int s = 0; s < mpsm_pkg::ALPHABET; s++) begin
                if (trie_valid[slot(cur, s)]) begin
                    nxt = trie_next[slot(cur, s)];
                    bq.push_back(nxt);
                    f = fail_node[cur];
                    while (!trie_valid[slot(f, s)]) f = fail_node[f];
                    f = trie_next[slot(f, s)];
                    fail_node[nxt] = f;
                    node_count[nxt] += node_count[f];
                end
            end
        end
    endfunction

    // Advances the model by one item and returns its result beat.
    function automatic t_match_res match_step(input logic [1:0] kind,
                                              input logic [7:0] sym,
                                              input logic last);
        t_match_res r;
        int st;
        longint sum;
        r = '{here: 0, total: 0, status: mpsm_pkg::ST_OK, done: 1'b0};
        case (kind)
            mpsm_pkg::KIND_PAT: begin
                if (is_built) r.status = mpsm_pkg::ST_ORDER;
                else if (pat_broken) r.status = mpsm_pkg::ST_FULL;
                else if (trie_valid[slot(ins_at, sym)]) ins_at = trie_next[slot(ins_at, sym)];
                else if (top_node + 1 < mpsm_pkg::MAX_NODES) begin
                    top_node++;
                    trie_valid[slot(ins_at, sym)] = 1'b1;
                    trie_next[slot(ins_at, sym)] = top_node[7:0];
                    ins_at = top_node;
                end else begin
                    pat_broken = 1'b1;
                    r.status = mpsm_pkg::ST_FULL;
                end
            end
            mpsm_pkg::KIND_END: begin
                if (is_built) r.status = mpsm_pkg::ST_ORDER;
                else if (pat_broken || pat_count >= mpsm_pkg::MAX_PATTERNS) begin
                    r.status = mpsm_pkg::ST_FULL;
                    pat_broken = 1'b0;
                    ins_at = 0;
                end else if (ins_at == 0) r.status = mpsm_pkg::ST_ORDER;
                else begin
                    node_count[ins_at]++;
                    pat_count++;
                    ins_at = 0;
                end
            end
            mpsm_pkg::KIND_BUILD: begin
                if (is_built || ins_at != 0 || pat_broken) r.status = mpsm_pkg::ST_ORDER;
                else begin
                    link_trie();
                    is_built = 1'b1;
                    scan_at = 0;
                    run_total = 0;
                    r.done = 1'b1;
                end
            end
            default: begin
                if (!is_built) r.status = mpsm_pkg::ST_ORDER;
                else begin
                    st = scan_at;
                    while (!trie_valid[slot(st, sym)]) st = fail_node[st];
                    scan_at = trie_next[slot(st, sym)];
                    r.here = node_count[scan_at][6:0];
                    sum = longint'(run_total) + node_count[scan_at];
                    run_total = (sum > 32'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
                    r.done = last;
                end
            end
        endcase
        r.total = run_total;
        if (kind == mpsm_pkg::KIND_TEXT && is_built && last) begin
            scan_at = 0;
            run_total = 0;
        end
        return r;
    endfunction

    // Offers one beat until it is taken, idling at random.
    task automatic send_item(input logic [1:0] kind, input logic [7:0] sym,
                             input logic last, input bit typed, input t_match_res want);
        t_match_res r;
        bit taken;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            push <= ($urandom_range(99) >= tx_idle);
            i_kind <= kind;
            i_symbol <= sym;
            i_text_last <= last;
            @(posedge i_clk);
            taken = push && !full;
        end
        r = match_step(kind, sym, last);
        pending_res.push_back(typed ? want : r);
        sent++;
        if (kind == mpsm_pkg::KIND_TEXT) text_bytes++;
        if (sent == 450) begin
            tx_idle = 69;
            rx_idle = 10;
        end else if (sent == 900) begin
            tx_idle = 0;
            rx_idle = 0;
        end
    endtask

    task automatic walk_rows(input t_stim_row rows[$]);
        foreach (rows[k]) send_item(rows[k].kind, rows[k].sym, rows[k].last,
                                    rows[k].chk, rows[k].res);
    endtask

    task automatic send_pattern(input int len, input bit wide);
        t_match_res none;
        none = '{here: 0, total: 0, status: mpsm_pkg::ST_OK, done: 1'b0};
        for (int k = 0; k < len; k++)
            send_item(mpsm_pkg::KIND_PAT,
                      wide ? 8'($urandom_range(255)) : 8'($urandom_range(99, 97)),
                      1'($urandom), 1'b0, none);
        send_item(mpsm_pkg::KIND_END, 8'($urandom), 1'($urandom), 1'b0, none);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH beat %0d %s: got %0d, expected %0d", received, what, got, want);
        errors++;
    endtask

    // Receiver: random pops, compare each beat with the oldest expectation.
    always @(negedge i_clk) pop <= i_rst_n && ($urandom_range(99) >= rx_idle);

    always @(posedge i_clk) begin
        t_match_res w;
        if (pop && !empty) begin
            if (pending_res.size() == 0) begin
                report_mismatch("unexpected beat", 1, 0);
            end else begin
                w = pending_res.pop_front();
                if (o_matches_here !== w.here)
                    report_mismatch("matches_here", o_matches_here, w.here);
                if (o_total_matches !== w.total)
                    report_mismatch("total_matches", o_total_matches, w.total);
                if (o_status !== w.status)
                    report_mismatch("status", o_status, w.status);
                if (o_done_res !== w.done)
                    report_mismatch("done_res", o_done_res, w.done);
                match_sum += w.here;
            end
            received++;
        end
    end

    // Watchdog on cycles with no beat moving on either side.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("watchdog expired with %0d beats outstanding", pending_res.size());
            $display("multi_pattern_string_matcher test failed");
            $finish;
        end
    end

    initial begin : stim
        t_stim_row pre[$];
        t_stim_row post[$];
        t_match_res none, order, built;
        logic [7:0] sym;
        logic last;
        none  = '{here: 0, total: 0, status: mpsm_pkg::ST_OK, done: 1'b0};
        order = '{here: 0, total: 0, status: mpsm_pkg::ST_ORDER, done: 1'b0};
        built = '{here: 0, total: 0, status: mpsm_pkg::ST_OK, done: 1'b1};

        for (int k = 0; k < mpsm_pkg::GT_DEPTH; k++) begin
            trie_valid[k] = 1'b0;
            trie_next[k] = '0;
        end
        for (int k = 0; k < mpsm_pkg::MAX_NODES; k++) begin
            fail_node[k] = '0;
            node_count[k] = 0;
        end
        top_node = 0; ins_at = 0; scan_at = 0; pat_count = 0;
        run_total = 0; is_built = 0; pat_broken = 0;

        // Directed rows before the build: order errors, extremes, classic patterns.
        pre = '{
            '{mpsm_pkg::KIND_TEXT,  8'h61, 1'b1, 1'b1, order},
            '{mpsm_pkg::KIND_END,   8'hFF, 1'b0, 1'b1, order},
            '{mpsm_pkg::KIND_PAT,   8'h68, 1'b0, 1'b0, none},
            '{mpsm_pkg::KIND_PAT,   8'h65, 1'b1, 1'b0, none},
            '{mpsm_pkg::KIND_END,   8'h00, 1'b0, 1'b0, none},
            '{mpsm_pkg::KIND_PAT,   8'h73, 1'b0, 1'b0, none},
            '{mpsm_pkg::KIND_PAT,   8'h68, 1'b0, 1'b0, none},
            '{mpsm_pkg::KIND_PAT,   8'h65, 1'b0, 1'b0, none},
            '{mpsm_pkg::KIND_END,   8'h00, 1'b0, 1'b0, none},
            '{mpsm_pkg::KIND_PAT,   8'h00, 1'b0, 1'b0, none},
            '{mpsm_pkg::KIND_PAT,   8'hFF, 1'b0, 1'b0, none},
            '{mpsm_pkg::KIND_BUILD, 8'h00, 1'b0, 1'b1, order},
            '{mpsm_pkg::KIND_END,   8'h00, 1'b0, 1'b0, none}
        };

        // Build, then order errors after the build, then a classic text.
        post = '{
            '{mpsm_pkg::KIND_BUILD, 8'h00, 1'b0, 1'b1, built},
            '{mpsm_pkg::KIND_BUILD, 8'h00, 1'b0, 1'b1, order},
            '{mpsm_pkg::KIND_PAT,   8'h61, 1'b0, 1'b1, order},
            '{mpsm_pkg::KIND_END,   8'h00, 1'b0, 1'b1, order},
            '{mpsm_pkg::KIND_TEXT,  8'h75, 1'b0, 1'b0, none},
            '{mpsm_pkg::KIND_TEXT,  8'h73, 1'b0, 1'b0, none},
            '{mpsm_pkg::KIND_TEXT,  8'h68, 1'b0, 1'b0, none},
            '{mpsm_pkg::KIND_TEXT,  8'h65, 1'b0, 1'b0, none},
            '{mpsm_pkg::KIND_TEXT,  8'h72, 1'b0, 1'b0, none},
            '{mpsm_pkg::KIND_TEXT,  8'h73, 1'b1, 1'b0, none}
        };

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        walk_rows(pre);

        // Short patterns over a small alphabet give overlapping matches.
        for (int k = 0; k < 38; k++) send_pattern($urandom_range(4, 1), 1'b0);
        // Long random-byte patterns until the trie is full, then one that overflows.
        while (top_node < mpsm_pkg::MAX_NODES - 1) send_pattern(30, 1'b1);
        send_pattern(8, 1'b1);
        // Fill the pattern table and go one pattern past it.
        while (pat_count < mpsm_pkg::MAX_PATTERNS) send_pattern($urandom_range(3, 1), 1'b0);
        send_pattern(2, 1'b0);

        walk_rows(post);

        // Random text, mostly over the pattern letters, split into texts.
        for (int k = 0; k < TEXT_ITEMS; k++) begin
            sym = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                            : 8'($urandom_range(101, 97));
            last = (k == TEXT_ITEMS - 1) || ($urandom_range(39) == 0);
            send_item(mpsm_pkg::KIND_TEXT, sym, last, 1'b0, none);
        end
        @(negedge i_clk);
        push <= 1'b0;

        wait (received == sent);
        repeat (8) @(posedge i_clk);

        $display("covered %0d beats: order and full errors, trie overflow, build,", sent);
        $display("and %0d text bytes reporting %0d matches", text_bytes, match_sum);
        if (errors == 0) $display("multi_pattern_string_matcher test passed");
        else $display("multi_pattern_string_matcher test failed");
        $finish;
    end

endmodule
